// ===== rtl/ofdm_guard_window_overlap_core_macros.svh =====
`ifndef OFDM_GUARD_WINDOW_OVERLAP_CORE_MACROS_SVH
`define OFDM_GUARD_WINDOW_OVERLAP_CORE_MACROS_SVH

// property checked on every rising edge of clk_i, quiet while in reset
`define OGWO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define OGWO_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/ogwo_pkg.sv =====
// shared constants and controller/datapath interface types for the ofdm guard window block
`default_nettype none

package ogwo_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_IFFT_SIZE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRE_GUARD   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_POST_GUARD  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_OVERLAP_LEN = 2'd3;

  localparam logic [CFG_W-1:0] RST_IFFT_SIZE   = 11'd64;
  localparam logic [CFG_W-1:0] RST_PRE_GUARD   = 11'd16;
  localparam logic [CFG_W-1:0] RST_POST_GUARD  = 11'd0;
  localparam logic [CFG_W-1:0] RST_OVERLAP_LEN = 11'd0;

  // settle count start after a register changes, runs down to zero to wait
  // past the five clamp stages
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  typedef struct packed {
    logic clear_we;
    logic restart;
    logic take;
    logic mul_en;
    logic weigh_en;
    logic finish_en;
  } ogwo_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic win_item;
    logic tail;
    logic can_emit;
  } ogwo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ogwo_cfg.sv =====
// apb register file and pipelined clamping of the symbol settings
`default_nettype none

module ogwo_cfg #(
  parameter int unsigned MAX_N       = 1024,
  parameter int unsigned MAX_OVERLAP = 1536,
  localparam int unsigned LW = $clog2(3 * MAX_N + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ogwo_pkg::PADDR_W-1:0]      paddr,
  input  logic [ogwo_pkg::PDATA_W-1:0]      pwdata,
  output logic [ogwo_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output logic                              wr_o,
  output logic [LW-1:0]                     n_o,
  output logic [LW-1:0]                     p_o,
  output logic [LW-1:0]                     i_o,
  output logic [LW-1:0]                     l_o,
  output logic [LW-1:0]                     nmp_o,
  output logic [LW-1:0]                     pn_o,
  output logic [LW-1:0]                     lmi_o
);

  localparam int unsigned SW  = ((LW > ogwo_pkg::CFG_W) ? LW : ogwo_pkg::CFG_W) + 1;
  localparam int unsigned EXT = SW - ogwo_pkg::CFG_W;
  // overlap can never exceed the longest possible symbol, 3 * MAX_N, so cap the limit there
  localparam int unsigned OVC = (MAX_OVERLAP > 3 * MAX_N) ? 3 * MAX_N : MAX_OVERLAP;

  logic [ogwo_pkg::REG_IDX_W-1:0] reg_idx;
  logic [ogwo_pkg::CFG_W-1:0]     raw_n_q, raw_p_q, raw_q_q, raw_i_q;
  logic [SW-1:0]                  rn, rp, rq, ri;
  logic [SW-1:0]                  n1_d, p2_d, q2_d, i4_a, i4_b, i4_d, l_half;
  logic [SW-1:0]                  n1_q, p2_q, q2_q, pq3_q, l3_q, i4_q, nmp_q, pn_q, lmi_q;

  assign pready  = 1'b1;
  assign wr_o    = psel & penable & pwrite;
  assign reg_idx = paddr[ogwo_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_n_q <= ogwo_pkg::RST_IFFT_SIZE;
      raw_p_q <= ogwo_pkg::RST_PRE_GUARD;
      raw_q_q <= ogwo_pkg::RST_POST_GUARD;
      raw_i_q <= ogwo_pkg::RST_OVERLAP_LEN;
    end else if (wr_o) begin
      case (reg_idx)
        ogwo_pkg::REG_IFFT_SIZE:   raw_n_q <= pwdata[ogwo_pkg::CFG_W-1:0];
        ogwo_pkg::REG_PRE_GUARD:   raw_p_q <= pwdata[ogwo_pkg::CFG_W-1:0];
        ogwo_pkg::REG_POST_GUARD:  raw_q_q <= pwdata[ogwo_pkg::CFG_W-1:0];
        ogwo_pkg::REG_OVERLAP_LEN: raw_i_q <= pwdata[ogwo_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      ogwo_pkg::REG_IFFT_SIZE:   prdata = {{(ogwo_pkg::PDATA_W-ogwo_pkg::CFG_W){1'b0}}, raw_n_q};
      ogwo_pkg::REG_PRE_GUARD:   prdata = {{(ogwo_pkg::PDATA_W-ogwo_pkg::CFG_W){1'b0}}, raw_p_q};
      ogwo_pkg::REG_POST_GUARD:  prdata = {{(ogwo_pkg::PDATA_W-ogwo_pkg::CFG_W){1'b0}}, raw_q_q};
      ogwo_pkg::REG_OVERLAP_LEN: prdata = {{(ogwo_pkg::PDATA_W-ogwo_pkg::CFG_W){1'b0}}, raw_i_q};
      default:                   prdata = '0;
    endcase
  end

  assign rn = {{EXT{1'b0}}, raw_n_q};
  assign rp = {{EXT{1'b0}}, raw_p_q};
  assign rq = {{EXT{1'b0}}, raw_q_q};
  assign ri = {{EXT{1'b0}}, raw_i_q};
  assign l_half = l3_q >> 1;

  always_comb begin
    n1_d = rn;
    if (rn < SW'(1)) begin
      n1_d = SW'(1);
    end else if (rn > SW'(MAX_N)) begin
      n1_d = SW'(MAX_N);
    end
    p2_d = (rp > n1_q) ? n1_q : rp;
    q2_d = (rq > n1_q) ? n1_q : rq;
    i4_a = (ri > pq3_q) ? pq3_q : ri;
    i4_b = (i4_a > l_half) ? l_half : i4_a;
    i4_d = (i4_b > SW'(OVC)) ? SW'(OVC) : i4_b;
  end

  // five register stages: n, then p/q, then sums and n-p, then overlap, then l minus overlap
  always_ff @(posedge clk_i) begin
    n1_q  <= n1_d;
    p2_q  <= p2_d;
    q2_q  <= q2_d;
    pq3_q <= p2_q + q2_q;
    l3_q  <= p2_q + q2_q + n1_q;
    i4_q  <= i4_d;
    nmp_q <= n1_q - p2_q;
    pn_q  <= p2_q + n1_q;
    lmi_q <= l3_q - i4_q;
  end

  assign n_o   = n1_q[LW-1:0];
  assign p_o   = p2_q[LW-1:0];
  assign i_o   = i4_q[LW-1:0];
  assign l_o   = l3_q[LW-1:0];
  assign nmp_o = nmp_q[LW-1:0];
  assign pn_o  = pn_q[LW-1:0];
  assign lmi_o = lmi_q[LW-1:0];

endmodule

`default_nettype wire

// ===== rtl/ogwo_ctrl.sv =====
// sequencer for memory clear, settings settle and the per-coefficient steps
`default_nettype none

module ogwo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cfg_wr_i,
  input  ogwo_pkg::ogwo_stat_t stat_i,
  output logic                 in_ready_o,
  output ogwo_pkg::ogwo_cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_SETTLE = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_WEIGH  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [ogwo_pkg::SETTLE_W-1:0] settle_q, settle_d;

  always_comb begin
    state_d    = state_q;
    settle_d   = settle_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (stat_i.clear_last) begin
          state_d  = ST_SETTLE;
          settle_d = ogwo_pkg::SETTLE_W'(ogwo_pkg::SETTLE_CYCLES);
        end
      end
      ST_SETTLE: begin
        if (settle_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          settle_d = settle_q - 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = ~cfg_wr_i;
        if (in_valid_i && !cfg_wr_i) begin
          cmd_o.take = 1'b1;
          // loads and out-of-phase items finish in this cycle
          if (stat_i.win_item) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_WEIGH;
      end
      ST_WEIGH: begin
        cmd_o.weigh_en = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.tail || stat_i.can_emit) begin
          cmd_o.finish_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d  = ST_SETTLE;
        settle_d = ogwo_pkg::SETTLE_W'(ogwo_pkg::SETTLE_CYCLES);
      end
    endcase

    // a register write drops the symbol in progress and waits for the clamps
    if (cfg_wr_i) begin
      cmd_o.restart = 1'b1;
      if (state_q != ST_CLEAR) begin
        state_d  = ST_SETTLE;
        settle_d = ogwo_pkg::SETTLE_W'(ogwo_pkg::SETTLE_CYCLES);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      settle_q <= '0;
    end else begin
      state_q  <= state_d;
      settle_q <= settle_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ogwo_dp.sv =====
// datapath: sample and overlap memories, index counters, weighting and overlap-add
`default_nettype none

module ogwo_dp #(
  parameter int unsigned MAX_N        = 1024,
  parameter int unsigned MAX_OVERLAP  = 1536,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned WINDOW_WIDTH = 16,
  localparam int unsigned LW = $clog2(3 * MAX_N + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ogwo_pkg::ogwo_cmd_t            cmd_i,
  output ogwo_pkg::ogwo_stat_t           stat_o,
  input  logic                           action_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_im_i,
  input  logic [WINDOW_WIDTH-1:0]        window_coef_i,
  input  logic [LW-1:0]                  n_i,
  input  logic [LW-1:0]                  p_i,
  input  logic [LW-1:0]                  i_i,
  input  logic [LW-1:0]                  l_i,
  input  logic [LW-1:0]                  nmp_i,
  input  logic [LW-1:0]                  pn_i,
  input  logic [LW-1:0]                  lmi_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_re_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_im_o,
  output logic                           last_o
);

  localparam int unsigned NW  = $clog2(MAX_N + 1);
  localparam int unsigned SAW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned OAW = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
  localparam int unsigned KW  = (OAW > LW) ? OAW : LW;
  localparam int unsigned DW  = 2 * SAMPLE_WIDTH;
  localparam int unsigned PW  = SAMPLE_WIDTH + WINDOW_WIDTH + 1;

  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // floor shift by the coefficient's fraction bits, then saturate
  function automatic logic [SAMPLE_WIDTH-1:0] sat_prod(input logic signed [PW-1:0] v);
    logic signed [PW-1:0]          s;
    logic [PW-SAMPLE_WIDTH:0]      top;
    logic [SAMPLE_WIDTH-1:0]       r;
    s   = v >>> (WINDOW_WIDTH - 1);
    top = s[PW-1:SAMPLE_WIDTH-1];
    if ((&top) || (~|top)) begin
      r = s[SAMPLE_WIDTH-1:0];
    end else begin
      r = s[PW-1] ? S_MIN : S_MAX;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] sat_sum(input logic [SAMPLE_WIDTH-1:0] a,
                                                      input logic [SAMPLE_WIDTH-1:0] b);
    logic [SAMPLE_WIDTH:0]   s;
    logic [SAMPLE_WIDTH-1:0] r;
    s = {a[SAMPLE_WIDTH-1], a} + {b[SAMPLE_WIDTH-1], b};
    if (s[SAMPLE_WIDTH] == s[SAMPLE_WIDTH-1]) begin
      r = s[SAMPLE_WIDTH-1:0];
    end else begin
      r = s[SAMPLE_WIDTH] ? S_MIN : S_MAX;
    end
    return r;
  endfunction

  // control state
  logic [NW-1:0]  load_cnt_q, load_next;
  logic [LW-1:0]  win_idx_q, win_next;
  logic           phase_q;
  logic [OAW-1:0] clr_addr_q;
  logic           out_valid_q;

  // per-coefficient payload
  logic [WINDOW_WIDTH-1:0]  coef_q;
  logic                     use_ov_q, tail_q, last_q;
  logic [OAW-1:0]           k_q;
  logic signed [PW-1:0]     prod_re_q, prod_im_q;
  logic [SAMPLE_WIDTH-1:0]  w_re_q, w_im_q;
  logic [SAMPLE_WIDTH-1:0]  out_re_q, out_im_q;
  logic                     out_last_q;

  logic [LW-1:0]            src;
  logic                     use_ov_d, tail_d, last_d;
  logic [KW-1:0]            k_full, ov_raddr_full;
  logic                     smp_we, win_take;

  logic [DW-1:0]            smp_mem [MAX_N];
  logic [DW-1:0]            smp_rd_q;
  logic [DW-1:0]            ov_mem [MAX_OVERLAP];
  logic [DW-1:0]            ov_rd_q;
  logic                     ov_we;
  logic [OAW-1:0]           ov_waddr;
  logic [DW-1:0]            ov_wdata;
  logic [SAMPLE_WIDTH-1:0]  ov_add_re, ov_add_im;

  assign smp_we    = cmd_i.take & ~phase_q & ~action_i;
  assign win_take  = cmd_i.take & phase_q & action_i;
  assign load_next = load_cnt_q + 1'b1;
  assign win_next  = win_idx_q + 1'b1;

  // prefix from the end of the symbol, then the body, then the postfix from the start
  always_comb begin
    if (win_idx_q < p_i) begin
      src = win_idx_q + nmp_i;
    end else if (win_idx_q < pn_i) begin
      src = win_idx_q - p_i;
    end else begin
      src = win_idx_q - pn_i;
    end
  end

  assign use_ov_d      = win_idx_q < i_i;
  assign tail_d        = win_idx_q >= lmi_i;
  assign last_d        = win_next == lmi_i;
  assign k_full        = KW'(win_idx_q) - KW'(lmi_i);
  assign ov_raddr_full = use_ov_d ? KW'(win_idx_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      win_idx_q   <= '0;
      phase_q     <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        load_cnt_q <= '0;
        win_idx_q  <= '0;
        phase_q    <= 1'b0;
      end else if (smp_we) begin
        if (load_next == n_i[NW-1:0]) begin
          load_cnt_q <= '0;
          win_idx_q  <= '0;
          phase_q    <= 1'b1;
        end else begin
          load_cnt_q <= load_next;
        end
      end else if (win_take) begin
        if (win_next == l_i) begin
          load_cnt_q <= '0;
          win_idx_q  <= '0;
          phase_q    <= 1'b0;
        end else begin
          win_idx_q <= win_next;
        end
      end

      if (cmd_i.clear_we) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end

      if (cmd_i.finish_en && !tail_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample memory: one write port for loading, one registered read port
  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[load_cnt_q[SAW-1:0]] <= {sample_re_i, sample_im_i};
    end
    if (win_take) begin
      smp_rd_q <= smp_mem[src[SAW-1:0]];
    end
  end

  // overlap memory is written by the clear sweep and by tail products
  assign ov_we    = cmd_i.clear_we | (cmd_i.finish_en & tail_q);
  assign ov_waddr = cmd_i.clear_we ? clr_addr_q : k_q;
  assign ov_wdata = cmd_i.clear_we ? '0 : {w_re_q, w_im_q};

  always_ff @(posedge clk_i) begin
    if (ov_we) begin
      ov_mem[ov_waddr] <= ov_wdata;
    end
    if (win_take) begin
      ov_rd_q <= ov_mem[ov_raddr_full[OAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_take) begin
      coef_q   <= window_coef_i;
      use_ov_q <= use_ov_d;
      tail_q   <= tail_d;
      last_q   <= last_d;
      k_q      <= k_full[OAW-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_re_q <= $signed(smp_rd_q[DW-1:SAMPLE_WIDTH]) * $signed({1'b0, coef_q});
      prod_im_q <= $signed(smp_rd_q[SAMPLE_WIDTH-1:0]) * $signed({1'b0, coef_q});
    end
    if (cmd_i.weigh_en) begin
      w_re_q <= sat_prod(prod_re_q);
      w_im_q <= sat_prod(prod_im_q);
    end
    if (cmd_i.finish_en && !tail_q) begin
      out_re_q   <= sat_sum(w_re_q, ov_add_re);
      out_im_q   <= sat_sum(w_im_q, ov_add_im);
      out_last_q <= last_q;
    end
  end

  assign ov_add_re = use_ov_q ? ov_rd_q[DW-1:SAMPLE_WIDTH] : '0;
  assign ov_add_im = use_ov_q ? ov_rd_q[SAMPLE_WIDTH-1:0] : '0;

  assign stat_o.clear_last = clr_addr_q == OAW'(MAX_OVERLAP - 1);
  assign stat_o.win_item   = phase_q & action_i;
  assign stat_o.tail       = tail_q;
  assign stat_o.can_emit   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/ofdm_guard_window_overlap_core.sv =====
// top level: ofdm symbol builder with cyclic prefix/postfix, windowing and overlap-add
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    action, sample_re, sample_im, window_coef
//   output   out        out_valid/out_ready  out_re, out_im, last
//   config   in         apb psel/penable     paddr, pwdata, prdata
//
// a sample load finishes when it is taken; a window coefficient goes through sample and
// overlap memory read, the multiplier, the shift and saturate, then the overlap add
// the last step of a non-tail coefficient holds while a result still sits unread in the output register
// after reset the overlap memory is cleared, then the settings settle
// each register write drops the symbol in progress and blocks input while the settings settle
`default_nettype none

module ofdm_guard_window_overlap_core #(
  parameter int unsigned MAX_N        = 1024,
  parameter int unsigned MAX_OVERLAP  = 1536,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned WINDOW_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_im_i,
  input  logic [WINDOW_WIDTH-1:0]       window_coef_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_re_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_im_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ogwo_pkg::PADDR_W-1:0]  paddr,
  input  logic [ogwo_pkg::PDATA_W-1:0]  pwdata,
  output logic [ogwo_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned LW = $clog2(3 * MAX_N + 1);

  ogwo_pkg::ogwo_cmd_t  cmd;
  ogwo_pkg::ogwo_stat_t stat;
  logic                 cfg_wr;
  logic [LW-1:0]        set_n, set_p, set_i, set_l, set_nmp, set_pn, set_lmi;

  ogwo_cfg #(
    .MAX_N       (MAX_N),
    .MAX_OVERLAP (MAX_OVERLAP)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wr_o    (cfg_wr),
    .n_o     (set_n),
    .p_o     (set_p),
    .i_o     (set_i),
    .l_o     (set_l),
    .nmp_o   (set_nmp),
    .pn_o    (set_pn),
    .lmi_o   (set_lmi)
  );

  ogwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_wr_i   (cfg_wr),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  ogwo_dp #(
    .MAX_N        (MAX_N),
    .MAX_OVERLAP  (MAX_OVERLAP),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .sample_re_i   (sample_re_i),
    .sample_im_i   (sample_im_i),
    .window_coef_i (window_coef_i),
    .n_i           (set_n),
    .p_i           (set_p),
    .i_i           (set_i),
    .l_i           (set_l),
    .nmp_i         (set_nmp),
    .pn_i          (set_pn),
    .lmi_i         (set_lmi),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_re_o      (out_re_o),
    .out_im_o      (out_im_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ogwo_checker.sv =====
// port-level checks for the ofdm guard window block, bound to the top level
`default_nettype none

`include "ofdm_guard_window_overlap_core_macros.svh"

module ogwo_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    action_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_re_o,
  input logic [SAMPLE_WIDTH-1:0] out_im_o,
  input logic                    last_o,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite
);

  // a result waiting for the sink holds still
  `OGWO_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_re_o) && $stable(out_im_o) && $stable(last_o), "output changed while stalled")

  // a register write blocks the input while the settings settle
  `OGWO_ASSERT_NEXT(a_cfg_blocks_input, psel && penable && pwrite, !in_ready_o, "input ready right after a register write")

  // a fresh result must follow the coefficient transfer that made it
  `OGWO_ASSERT(a_result_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && action_i, 4), "result without matching coefficient transfer")

endmodule

bind ofdm_guard_window_overlap_core ogwo_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ogwo_checker (.*);

`default_nettype wire
